// File: rtl/snbin_pkg.sv
// Shared constants, types and codes of the adaptive binarizer.
package snbin_pkg;

  // Largest supported image and window.
  localparam int unsigned MAX_WIDTH       = 2048;
  localparam int unsigned MAX_HEIGHT      = 2048;
  localparam int unsigned MAX_HALF_WINDOW = 15;

  // Widths that follow from the limits.
  localparam int unsigned W_W       = $clog2(MAX_WIDTH + 1);
  localparam int unsigned H_W       = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned HW_W      = $clog2(MAX_HALF_WINDOW + 1);
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W     = $clog2(MAX_HEIGHT);
  localparam int unsigned RING_ROWS = 3 * MAX_HALF_WINDOW + 1;
  localparam int unsigned RING_W    = $clog2(RING_ROWS);
  localparam int unsigned ADDR_W    = RING_W + COL_W;
  localparam int unsigned POS_W     = W_W + H_W + 1;
  localparam int unsigned SIDE_W    = $clog2(2 * MAX_HALF_WINDOW + 2);
  localparam int unsigned CNT_W     = 2 * SIDE_W;
  localparam int unsigned SUM_W     = 8 + CNT_W;
  localparam int unsigned SQ_W      = 16 + CNT_W;
  localparam int unsigned NUM_W     = CNT_W + SQ_W;
  localparam int unsigned DVD_W     = NUM_W + 16;
  localparam int unsigned DVS_W     = 2 * CNT_W;
  localparam int unsigned VAR_W     = 32;
  localparam int unsigned ROOT_W    = VAR_W / 2;
  localparam int unsigned BIT_W     = $clog2(ROOT_W);

  // Fixed widths of the register port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH    = 3'd0,
    CFG_IMAGE_HEIGHT   = 3'd1,
    CFG_HALF_WINDOW    = 3'd2,
    CFG_THRESHOLD_MODE = 3'd3,
    CFG_GAIN_K         = 3'd4,
    CFG_DYNAMIC_RANGE  = 3'd5
  } cfg_idx_e;

  // Threshold formulas.
  typedef enum logic {
    MODE_SAUVOLA = 1'b0,
    MODE_NIBLACK = 1'b1
  } mode_e;

  // Input request kinds.
  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_kind_e;

  // Input beat.
  typedef struct packed {
    logic       req_type;
    logic [7:0] gray_level;
  } req_t;

  // Result beat.
  typedef struct packed {
    logic out_bit;
    logic frame_last;
  } res_t;

  // Effective configuration after clamping.
  typedef struct packed {
    logic [W_W-1:0]    w;
    logic [H_W-1:0]    hgt;
    logic [HW_W-1:0]   h;
    mode_e             mode;
    logic signed [15:0] k;
    logic [9:0]        rr;
  } cfg_t;

  // One window job handed from front to back.
  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [RING_W-1:0] ring;
    logic              last;
  } job_t;

  // Pixel write into the row store.
  typedef struct packed {
    logic              en;
    logic [RING_W-1:0] ring;
    logic [COL_W-1:0]  col;
    logic [7:0]        data;
  } wr_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    B_IDLE,
    B_INIT,
    B_SUM,
    B_DRAIN,
    B_MEAN_GO,
    B_MEAN_WAIT,
    B_VAR_MUL,
    B_VAR_GO,
    B_VAR_WAIT,
    B_SQRT,
    B_THR_MUL,
    B_THR_SUM,
    B_CMP_MUL,
    B_PUSH
  } back_state_e;

endpackage

// File: rtl/snbin_jobq.sv
// Two-entry queue of window jobs between the front and the back.
module snbin_jobq import snbin_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic full_o,
  output logic empty_o
);

  job_t       slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  assign job_o   = slot_q[rd_q];
  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;

endmodule

// File: rtl/snbin_front.sv
// Front end: tracks raster positions, writes pixels and issues window jobs.
module snbin_front import snbin_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic push_i,
  input  req_t in_i,
  output logic full_o,
  input  logic jobq_full_i,
  input  logic jobq_empty_i,
  input  logic back_busy_i,
  output logic job_push_o,
  output job_t job_o,
  output wr_t  wr_o
);

  logic [POS_W-1:0]  in_pos_q, in_pos_d, out_pos_q, out_pos_d;
  logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RING_W-1:0] in_ring_q, in_ring_d, out_ring_q, out_ring_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;

  logic [POS_W-1:0]  n_pix, delay, in_e, out_e, in_next;
  logic [COL_W-1:0]  in_col_e, out_col_e, last_col;
  logic [RING_W-1:0] in_ring_e, out_ring_e;
  logic [ROW_W-1:0]  out_row_e;
  logic              clr, fresh, accept, pix_phase, counts;

  // Frame size and output lag from the live configuration.
  always_comb begin
    n_pix    = POS_W'(cfg_i.w) * POS_W'(cfg_i.hgt);
    delay    = POS_W'(cfg_i.h) * POS_W'(cfg_i.w) + POS_W'(cfg_i.h);
    last_col = COL_W'(cfg_i.w - W_W'(1));
  end

  // Positions as seen by the next beat; a finished frame restarts.
  always_comb begin
    clr        = out_pos_q >= n_pix;
    in_e       = clr ? '0 : in_pos_q;
    out_e      = clr ? '0 : out_pos_q;
    in_col_e   = clr ? '0 : in_col_q;
    out_col_e  = clr ? '0 : out_col_q;
    in_ring_e  = clr ? '0 : in_ring_q;
    out_ring_e = clr ? '0 : out_ring_q;
    out_row_e  = clr ? '0 : out_row_q;
  end

  // A new frame waits until the old tail has left the row store.
  always_comb begin
    fresh     = in_e == '0;
    full_o    = jobq_full_i | (fresh & (back_busy_i | ~jobq_empty_i));
    accept    = push_i & ~full_o;
    pix_phase = in_e < n_pix;
    counts    = ~(pix_phase & (in_i.req_type == REQ_FLUSH));
    in_next   = in_e + POS_W'(1);
  end

  // Store write and job issue.
  always_comb begin
    wr_o.en    = accept & pix_phase & (in_i.req_type == REQ_PIXEL);
    wr_o.ring  = in_ring_e;
    wr_o.col   = in_col_e;
    wr_o.data  = in_i.gray_level;
    job_push_o = accept & counts & (in_next > out_e + delay);
    job_o.col  = out_col_e;
    job_o.row  = out_row_e;
    job_o.ring = out_ring_e;
    job_o.last = out_e == n_pix - POS_W'(1);
  end

  // Position updates on each accepted beat.
  always_comb begin
    in_pos_d   = in_pos_q;
    out_pos_d  = out_pos_q;
    in_col_d   = in_col_q;
    in_ring_d  = in_ring_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_ring_d = out_ring_q;
    if (accept) begin
      in_pos_d   = counts ? in_next : in_e;
      out_pos_d  = out_e;
      in_col_d   = in_col_e;
      in_ring_d  = in_ring_e;
      out_col_d  = out_col_e;
      out_row_d  = out_row_e;
      out_ring_d = out_ring_e;
      if (wr_o.en) begin
        if (in_col_e == last_col) begin
          in_col_d  = '0;
          in_ring_d = (in_ring_e == RING_W'(RING_ROWS - 1)) ? '0 : in_ring_e + RING_W'(1);
        end else begin
          in_col_d = in_col_e + COL_W'(1);
        end
      end
      if (job_push_o) begin
        out_pos_d = out_e + POS_W'(1);
        if (out_col_e == last_col) begin
          out_col_d  = '0;
          out_row_d  = out_row_e + ROW_W'(1);
          out_ring_d = (out_ring_e == RING_W'(RING_ROWS - 1)) ? '0 : out_ring_e + RING_W'(1);
        end else begin
          out_col_d = out_col_e + COL_W'(1);
        end
        if (out_e + POS_W'(1) >= n_pix) begin
          in_pos_d   = '0;
          out_pos_d  = '0;
          in_col_d   = '0;
          in_ring_d  = '0;
          out_col_d  = '0;
          out_row_d  = '0;
          out_ring_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pos_q   <= '0;
      out_pos_q  <= '0;
      in_col_q   <= '0;
      in_ring_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_ring_q <= '0;
    end else begin
      in_pos_q   <= in_pos_d;
      out_pos_q  <= out_pos_d;
      in_col_q   <= in_col_d;
      in_ring_q  <= in_ring_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_ring_q <= out_ring_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A job is never offered to a full queue.
  a_job_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o |-> !jobq_full_i) else $error("job pushed into full queue");

  // Pixel writes stay inside the configured row.
  a_wr_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |-> (W_W'(wr_o.col) < cfg_i.w)) else $error("pixel write beyond row");
`endif

endmodule

// File: rtl/snbin_div.sv
// Restoring divider, one quotient bit per cycle.
module snbin_div import snbin_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dvd_i,
  input  logic [DVS_W-1:0] dvs_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic             busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // One shift, compare and subtract step.
  always_comb begin
    rem_sh = {rem_q, quo_q[DVD_W-1]};
    fits   = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(DVD_W - 1);
      quo_d  = dvd_i;
      rem_d  = '0;
      dvs_d  = dvs_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DVD_W-2:0], fits};
      rem_d = fits ? DVS_W'(rem_sh - {1'b0, dvs_q}) : DVS_W'(rem_sh);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/snbin_back.sv
// Back end: row store, window scan, mean and deviation, threshold and result queue.
module snbin_back import snbin_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  wr_t  wr_i,
  input  job_t job_i,
  input  logic jobq_empty_i,
  output logic job_pop_o,
  output logic busy_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  // Row store: ring of rows, one write and one read port.
  logic [7:0]        mem [RING_ROWS * MAX_WIDTH];
  logic [7:0]        rd_data_q;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[{wr_i.ring, wr_i.col}] <= wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  back_state_e state_q, state_d;

  job_t              job_q;
  logic [ROW_W-1:0]  r_q, r1_q;
  logic [COL_W-1:0]  c_q, c0_q, c1_q;
  logic [RING_W-1:0] ring_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]   sq_q;
  logic              acc_v_q, cen_v_q;
  logic [7:0]        gray_q;
  logic [15:0]       m_q;
  logic [NUM_W-1:0]  p1_q, p2_q;
  logic [DVS_W-1:0]  nn_q;
  logic [VAR_W-1:0]  var_q;
  logic [ROOT_W-1:0] root_q;
  logic [BIT_W-1:0]  bit_q;
  logic signed [35:0] kd_q;
  logic [17:0]       gr_q;
  logic signed [37:0] tsum_q;
  logic signed [55:0] x_q, y_q;

  // Divider hookup.
  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dvd, div_quo;
  logic [DVS_W-1:0] div_dvs;

  snbin_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Result queue, two entries.
  res_t       rq_q [2];
  logic       rq_wr_q, rq_rd_q;
  logic [1:0] rq_cnt_q;
  logic       rq_full, res_push;
  res_t       res_new;

  assign rq_full = rq_cnt_q == 2'd2;
  assign empty_o = rq_cnt_q == 2'd0;
  assign res_o   = rq_q[rq_rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        rq_wr_q <= ~rq_wr_q;
      end
      if (pop_i && !empty_o) begin
        rq_rd_q <= ~rq_rd_q;
      end
      rq_cnt_q <= rq_cnt_q + 2'(res_push) - 2'(pop_i && !empty_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      rq_q[rq_wr_q] <= res_new;
    end
  end

  // Window bounds of the job, clipped to the image.
  logic [ROW_W-1:0]  r0_c, r1_c, h_row;
  logic [COL_W-1:0]  c0_c, c1_c, h_col;
  logic [ROW_W:0]    rsum;
  logic [COL_W:0]    csum;
  logic [RING_W:0]   back_rows;
  logic [RING_W-1:0] ring0_c;
  logic [CNT_W-1:0]  cnt_c;

  always_comb begin
    h_row     = ROW_W'(cfg_i.h);
    h_col     = COL_W'(cfg_i.h);
    r0_c      = (job_q.row >= h_row) ? job_q.row - h_row : '0;
    c0_c      = (job_q.col >= h_col) ? job_q.col - h_col : '0;
    rsum      = (ROW_W+1)'(job_q.row) + (ROW_W+1)'(h_row);
    csum      = (COL_W+1)'(job_q.col) + (COL_W+1)'(h_col);
    r1_c      = ((H_W+1)'(rsum) < (H_W+1)'(cfg_i.hgt)) ? ROW_W'(rsum)
                                                       : ROW_W'(cfg_i.hgt - H_W'(1));
    c1_c      = ((W_W+1)'(csum) < (W_W+1)'(cfg_i.w)) ? COL_W'(csum)
                                                     : COL_W'(cfg_i.w - W_W'(1));
    back_rows = (RING_W+1)'(job_q.row - r0_c);
    ring0_c   = ((RING_W+1)'(job_q.ring) >= back_rows)
              ? RING_W'((RING_W+1)'(job_q.ring) - back_rows)
              : RING_W'((RING_W+1)'(job_q.ring) + (RING_W+1)'(RING_ROWS) - back_rows);
    cnt_c     = CNT_W'(SIDE_W'(r1_c - r0_c) + SIDE_W'(1))
              * CNT_W'(SIDE_W'(c1_c - c0_c) + SIDE_W'(1));
  end

  logic scan_end;
  assign scan_end = (r_q == r1_q) && (c_q == c1_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:      if (!jobq_empty_i) state_d = B_INIT;
      B_INIT:      state_d = B_SUM;
      B_SUM:       if (scan_end) state_d = B_DRAIN;
      B_DRAIN:     state_d = B_MEAN_GO;
      B_MEAN_GO:   state_d = B_MEAN_WAIT;
      B_MEAN_WAIT: if (div_done) state_d = B_VAR_MUL;
      B_VAR_MUL:   state_d = B_VAR_GO;
      B_VAR_GO:    state_d = B_VAR_WAIT;
      B_VAR_WAIT:  if (div_done) state_d = B_SQRT;
      B_SQRT:      if (bit_q == '0) state_d = B_THR_MUL;
      B_THR_MUL:   state_d = B_THR_SUM;
      B_THR_SUM:   state_d = B_CMP_MUL;
      B_CMP_MUL:   state_d = B_PUSH;
      B_PUSH:      if (!rq_full) state_d = B_IDLE;
      default:     state_d = B_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    job_pop_o = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = {ring_q, c_q};
    div_start = 1'b0;
    div_dvd   = {{(DVD_W-SUM_W-8){1'b0}}, sum_q, 8'b0};
    div_dvs   = DVS_W'(cnt_q);
    res_push  = 1'b0;
    case (state_q)
      B_IDLE: begin
        job_pop_o = !jobq_empty_i;
      end
      B_INIT: begin
        rd_en   = 1'b1;
        rd_addr = {job_q.ring, job_q.col};
      end
      B_SUM: begin
        rd_en = 1'b1;
      end
      B_MEAN_GO: begin
        div_start = 1'b1;
      end
      B_VAR_GO: begin
        div_start = 1'b1;
        div_dvd   = {p1_q - p2_q, 16'b0};
        div_dvs   = nn_q;
      end
      B_PUSH: begin
        res_push = !rq_full;
      end
      default: begin
      end
    endcase
    res_new.out_bit    = x_q < y_q;
    res_new.frame_last = job_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      acc_v_q <= 1'b0;
      cen_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_v_q <= state_q == B_SUM;
      cen_v_q <= state_q == B_INIT;
    end
  end

  // Square root trial and threshold terms.
  logic [ROOT_W-1:0]  trial;
  logic signed [19:0] diff;

  always_comb begin
    trial = root_q | (ROOT_W'(1) << bit_q);
    diff  = $signed({4'b0, root_q}) - $signed({2'b0, cfg_i.rr, 8'b0});
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && !jobq_empty_i) begin
      job_q <= job_i;
    end
    if (acc_v_q) begin
      sum_q <= sum_q + SUM_W'(rd_data_q);
      sq_q  <= sq_q + SQ_W'(16'(rd_data_q) * 16'(rd_data_q));
    end
    if (cen_v_q) begin
      gray_q <= rd_data_q;
    end
    case (state_q)
      B_INIT: begin
        r_q    <= r0_c;
        r1_q   <= r1_c;
        c_q    <= c0_c;
        c0_q   <= c0_c;
        c1_q   <= c1_c;
        ring_q <= ring0_c;
        cnt_q  <= cnt_c;
        sum_q  <= '0;
        sq_q   <= '0;
      end
      B_SUM: begin
        if (c_q == c1_q) begin
          c_q    <= c0_q;
          r_q    <= r_q + ROW_W'(1);
          ring_q <= (ring_q == RING_W'(RING_ROWS - 1)) ? '0 : ring_q + RING_W'(1);
        end else begin
          c_q <= c_q + COL_W'(1);
        end
      end
      B_MEAN_WAIT: begin
        if (div_done) begin
          m_q <= div_quo[15:0];
        end
      end
      B_VAR_MUL: begin
        p1_q <= NUM_W'(cnt_q) * NUM_W'(sq_q);
        p2_q <= NUM_W'(sum_q) * NUM_W'(sum_q);
        nn_q <= DVS_W'(cnt_q) * DVS_W'(cnt_q);
      end
      B_VAR_WAIT: begin
        if (div_done) begin
          var_q  <= div_quo[VAR_W-1:0];
          root_q <= '0;
          bit_q  <= BIT_W'(ROOT_W - 1);
        end
      end
      B_SQRT: begin
        if (VAR_W'(trial) * VAR_W'(trial) <= var_q) begin
          root_q <= trial;
        end
        bit_q <= bit_q - BIT_W'(1);
      end
      B_THR_MUL: begin
        if (cfg_i.mode == MODE_SAUVOLA) begin
          kd_q <= cfg_i.k * diff;
        end else begin
          kd_q <= cfg_i.k * $signed({4'b0, root_q});
        end
        gr_q <= 18'(gray_q) * 18'(cfg_i.rr);
      end
      B_THR_SUM: begin
        if (cfg_i.mode == MODE_SAUVOLA) begin
          tsum_q <= 38'($signed({1'b0, cfg_i.rr, 20'b0})) + 38'(kd_q);
        end else begin
          tsum_q <= 38'($signed({1'b0, m_q, 12'b0})) + 38'(kd_q);
        end
      end
      B_CMP_MUL: begin
        // Compare the scaled gray level against the equally scaled threshold without dividing.
        if (cfg_i.mode == MODE_SAUVOLA) begin
          x_q <= $signed({1'b0, m_q}) * tsum_q;
          y_q <= 56'($signed({1'b0, gr_q, 28'b0}));
        end else begin
          x_q <= 56'(tsum_q);
          y_q <= 56'($signed({1'b0, gray_q, 20'b0}));
        end
      end
      default: begin
      end
    endcase
  end

  assign busy_o = state_q != B_IDLE;

`ifndef NO_ASSERTIONS
  // The divider is only started while it is free.
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  // A window always holds at least one pixel.
  a_cnt_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_MEAN_GO) |-> (cnt_q != '0)) else $error("empty window");

  // The result queue never overflows.
  a_rq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !rq_full) else $error("result queue overflow");
`endif

endmodule

// File: rtl/sauvola_niblack_binarizer_top.sv
// Top level of the Sauvola / Niblack adaptive binarizer.
//
//   channel   direction  handshake              payload
//   input     in         push_i / full_o        in_i (req_t)
//   result    out        pop_i / empty_o        res_o (res_t)
//   config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// Each result costs row-store scanning of the window pixels on the single read
// port, plus a mean and a variance divider pass, ROOT_W square-root steps and
// the fixed sequencer states around them.
// Reset clears all control state; the row store has no clearing pass.
// The front stalls when its job queue is full or when a new frame would start
// before the back has finished the previous frame's tail.
module sauvola_niblack_binarizer_top import snbin_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  req_t                  in_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output res_t                  res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [11:0] width_q, height_q;
  logic [3:0]  half_q;
  logic        mode_q;
  logic [15:0] gain_q;
  logic [9:0]  range_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd256;
      height_q <= 12'd256;
      half_q   <= 4'd7;
      mode_q   <= 1'b0;
      gain_q   <= 16'd819;
      range_q  <= 10'd128;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:    width_q  <= cfg_data_i[11:0];
        CFG_IMAGE_HEIGHT:   height_q <= cfg_data_i[11:0];
        CFG_HALF_WINDOW:    half_q   <= cfg_data_i[3:0];
        CFG_THRESHOLD_MODE: mode_q   <= cfg_data_i[0];
        CFG_GAIN_K:         gain_q   <= cfg_data_i;
        CFG_DYNAMIC_RANGE:  range_q  <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp register values to the supported ranges.
  cfg_t cfg;
  always_comb begin
    cfg.w    = (width_q == '0) ? W_W'(1)
             : ((32'(width_q) > MAX_WIDTH) ? W_W'(MAX_WIDTH) : W_W'(width_q));
    cfg.hgt  = (height_q == '0) ? H_W'(1)
             : ((32'(height_q) > MAX_HEIGHT) ? H_W'(MAX_HEIGHT) : H_W'(height_q));
    cfg.h    = (32'(half_q) > MAX_HALF_WINDOW) ? HW_W'(MAX_HALF_WINDOW) : HW_W'(half_q);
    cfg.mode = mode_e'(mode_q);
    cfg.k    = $signed(gain_q);
    cfg.rr   = (range_q == '0) ? 10'd1 : range_q;
  end

  logic jobq_full, jobq_empty, job_push, job_pop, back_busy;
  job_t job_in, job_out;
  wr_t  wr;

  snbin_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .push_i       (push_i),
    .in_i         (in_i),
    .full_o       (full_o),
    .jobq_full_i  (jobq_full),
    .jobq_empty_i (jobq_empty),
    .back_busy_i  (back_busy),
    .job_push_o   (job_push),
    .job_o        (job_in),
    .wr_o         (wr)
  );

  snbin_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .job_o   (job_out),
    .full_o  (jobq_full),
    .empty_o (jobq_empty)
  );

  snbin_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .wr_i         (wr),
    .job_i        (job_out),
    .jobq_empty_i (jobq_empty),
    .job_pop_o    (job_pop),
    .busy_o       (back_busy),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .res_o        (res_o)
  );

endmodule
